// ===== rtl/core/rgbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGBE decoder package
// Shared constants and helpers for the RGBE scanline decoder.
// ----------------------------------------------------------------------------
package rgbe_pkg;

  localparam int unsigned MaxWidth   = 8192;
  localparam int unsigned StoreDepth = 4 * MaxWidth;
  localparam int unsigned AddrW      = $clog2(StoreDepth);

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_WIDTH   = 2'd1;
  localparam logic [1:0] ERR_RUN     = 2'd2;
  localparam logic [1:0] ERR_OVERRUN = 2'd3;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  // Exact float bits of m * 2^(e-136), e nonzero
  function automatic logic [31:0] to_float(input logic [7:0] m, input logic [7:0] e);
    logic [2:0]  p;
    logic [8:0]  be;
    logic [31:0] res;
    p   = 3'd0;
    res = 32'd0;
    for (int i = 0; i < 8; i++) begin
      if (m[i]) p = 3'(i);
    end
    // biased exponent = p + e - 9
    be = 9'({6'd0, p}) + 9'({1'b0, e});
    if (m == 8'd0) begin
      res = 32'd0;
    end else if (be >= 9'd10) begin
      res = {1'b0, 8'(be - 9'd9), 23'({15'd0, m} << (5'd23 - 5'({2'd0, p})))};
    end else begin
      // subnormal: m << (e + 13)
      res = 32'({24'd0, m}) << (6'({1'b0, e[4:0]}) + 6'd13);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rgbe_rle_scanline_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGBE adaptive run-length scanline decoder
// Decodes Radiance RGBE pixel bytes into float32 RGB pixels.
// ----------------------------------------------------------------------------
// Channel | Dir | Contents
// s_axis  | in  | tuser: cmd ; tdata: byte_value
// m_axis  | out | tuser: pixel_valid,end_of_line,end_of_image,error_code
//         |     | tdata: red, green, blue
// cfg     | in  | index 0 width, 1 height
// Data bytes and literal bytes are handled in their transfer; a run byte of
// length n is taken in its transfer, then one store write a cycle for n writes.
// A pull is taken in its transfer, then four plane reads through the single
// read port, then the pixel is formed.
// Reset clears all control state; the line store holds no reset value.
// A result waiting at the output stalls the input until it is transferred.
// Bytes that give no result, but for a run's value byte, can be transferred on consecutive cycles.
module rgbe_rle_scanline_decoder (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [0:0]  cfg_index_i,
  input  wire  [15:0] cfg_data_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // byte_value
  input  wire  [0:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [95:0] m_axis_tdata,   // red, green, blue
  output logic [4:0]  m_axis_tuser    // pixel_valid, end_of_line, end_of_image, error_code
);
  import rgbe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_PIX  = 2'd3;

  logic [13:0] width_q;
  logic [15:0] height_q;
  logic [1:0]  state_q;
  logic        raw_q, halted_q, begun_q, ready_q;
  logic [1:0]  plane_q, phase_q, gcnt_q;
  logic [13:0] pos_q, drain_q;
  logic [7:0]  run_q, runb_q;
  logic [23:0] gath_q;
  logic [31:0] left_q;
  logic        eol_q;
  logic [7:0]  rd_q [4];
  logic [1:0]  rdi_q;
  logic [7:0]  mem [StoreDepth];
  logic        we;
  logic [31:0] waddr_w, raddr_w;
  logic [7:0]  wdata;
  logic        ovld_q;
  logic [95:0] odata_q;
  logic [4:0]  ouser_q;

  assign s_axis_tready = (state_q == ST_IDLE) && !ovld_q;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  wire        acc  = s_axis_tvalid && s_axis_tready;
  wire [7:0]  b    = s_axis_tdata;
  wire [31:0] wpix = begun_q ? left_q : 32'(width_q) * 32'(height_q);
  wire [14:0] rem  = (pos_q < width_q) ? 15'(width_q - pos_q) : 15'd0;
  wire [7:0]  cnt  = b[7] && (b != 8'h80) ? {1'b0, b[6:0]} : b;

  // Store address: plane * width + position
  assign waddr_w = 32'(plane_q) * 32'(width_q) + 32'(pos_q);
  assign raddr_w = 32'(rdi_q) * 32'(width_q) + 32'(drain_q);

  always_ff @(posedge clk_i) begin
    if (we && waddr_w < 32'(StoreDepth)) mem[waddr_w[AddrW-1:0]] <= wdata;
    if (state_q == ST_READ)
      rd_q[rdi_q] <= (raddr_w < 32'(StoreDepth)) ? mem[raddr_w[AddrW-1:0]] : 8'd0;
  end

  always_comb begin
    we    = 1'b0;
    wdata = b;
    if (state_q == ST_RUN) begin
      we = 1'b1; wdata = runb_q;
    end else if (acc && !halted_q && wpix != 0 && s_axis_tuser == CMD_DATA && !ready_q
                 && phase_q == 2'd3) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 14'd8; height_q <= 16'd1; state_q <= ST_IDLE;
      raw_q <= 1'b0; halted_q <= 1'b0; begun_q <= 1'b0; ready_q <= 1'b0;
      plane_q <= '0; phase_q <= '0; gcnt_q <= '0; pos_q <= '0; drain_q <= '0;
      run_q <= '0; runb_q <= '0; gath_q <= '0; left_q <= '0; eol_q <= 1'b0;
      rdi_q <= '0; ovld_q <= 1'b0; odata_q <= '0; ouser_q <= '0;
    end else begin
      // Configuration writes
      if (cfg_we_i) begin
        if ({1'b0, cfg_index_i} == REG_WIDTH) width_q <= cfg_data_i[13:0];
        else height_q <= cfg_data_i;
      end
      // Drop transferred result
      if (ovld_q && m_axis_tready) ovld_q <= 1'b0;

      unique case (state_q)
        ST_RUN: begin
          // Advance one run byte a cycle
          pos_q <= pos_q + 14'd1;
          run_q <= run_q - 8'd1;
          if (run_q == 8'd1) begin
            state_q <= ST_IDLE;
            if (15'(pos_q) + 15'd1 >= 15'(width_q)) begin
              pos_q <= '0;
              if (plane_q == 2'd3) begin
                plane_q <= '0; ready_q <= 1'b1; drain_q <= '0; phase_q <= 2'd0;
              end else begin
                plane_q <= plane_q + 2'd1; phase_q <= 2'd1;
              end
            end else phase_q <= 2'd1;
          end
        end
        ST_READ: begin
          rdi_q <= rdi_q + 2'd1;
          if (rdi_q == 2'd3) state_q <= ST_PIX;
        end
        ST_PIX: begin
          // Emit drained pixel
          state_q <= ST_IDLE;
          ovld_q  <= 1'b1;
          left_q  <= left_q - 32'd1;
          odata_q <= (rd_q[3] == 8'd0) ? 96'd0 :
                     {to_float(rd_q[2], rd_q[3]), to_float(rd_q[1], rd_q[3]),
                      to_float(rd_q[0], rd_q[3])};
          ouser_q <= {ERR_NONE, left_q == 32'd1, eol_q, 1'b1};
        end
        default: begin
          if (acc && !halted_q) begin
            if (!begun_q) begin
              begun_q <= 1'b1; left_q <= wpix; drain_q <= '0;
            end
            if (wpix != 32'd0) begin
              if (s_axis_tuser == CMD_PULL) begin
                if (!raw_q && ready_q) begin
                  eol_q   <= 15'(drain_q) + 15'd1 >= 15'(width_q);
                  state_q <= ST_READ;
                  rdi_q   <= '0;
                end
              end else if (ready_q) begin
                halted_q <= 1'b1; ovld_q <= 1'b1; odata_q <= '0;
                ouser_q  <= {ERR_OVERRUN, 3'b000};
              end else if (phase_q == 2'd0) begin
                if (gcnt_q != 2'd3) begin
                  gath_q <= {gath_q[15:0], b}; gcnt_q <= gcnt_q + 2'd1;
                end else begin
                  gath_q <= '0; gcnt_q <= '0;
                  if (!raw_q && width_q >= 14'd8 && gath_q[23:16] == 8'd2
                      && gath_q[15:8] == 8'd2 && !gath_q[7]) begin
                    if ({gath_q[7:0], b} != {2'b00, width_q} || width_q > 14'(MaxWidth)) begin
                      halted_q <= 1'b1; ovld_q <= 1'b1; odata_q <= '0;
                      ouser_q  <= {ERR_WIDTH, 3'b000};
                    end else begin
                      plane_q <= '0; pos_q <= '0; run_q <= '0; phase_q <= 2'd1;
                    end
                  end else begin
                    raw_q   <= 1'b1;
                    drain_q <= (15'(drain_q) + 15'd1 >= 15'(width_q)) ? '0 : drain_q + 14'd1;
                    left_q  <= wpix - 32'd1;
                    ovld_q  <= 1'b1;
                    odata_q <= (b == 8'd0) ? 96'd0 :
                               {to_float(gath_q[7:0], b), to_float(gath_q[15:8], b),
                                to_float(gath_q[23:16], b)};
                    ouser_q <= {ERR_NONE, wpix == 32'd1,
                                15'(drain_q) + 15'd1 >= 15'(width_q), 1'b1};
                  end
                end
              end else if (phase_q == 2'd1) begin
                if (cnt == 8'd0 || 15'(cnt) > rem) begin
                  halted_q <= 1'b1; ovld_q <= 1'b1; odata_q <= '0;
                  ouser_q  <= {ERR_RUN, 3'b000};
                end else begin
                  run_q <= cnt; phase_q <= (b > 8'd128) ? 2'd2 : 2'd3;
                end
              end else if (phase_q == 2'd2) begin
                runb_q <= b; state_q <= ST_RUN;
              end else begin
                // Literal byte written this cycle
                pos_q <= pos_q + 14'd1;
                run_q <= run_q - 8'd1;
                if (15'(pos_q) + 15'd1 >= 15'(width_q)) begin
                  run_q <= '0; pos_q <= '0;
                  if (plane_q == 2'd3) begin
                    plane_q <= '0; ready_q <= 1'b1; drain_q <= '0; phase_q <= 2'd0;
                  end else begin
                    plane_q <= plane_q + 2'd1; phase_q <= 2'd1;
                  end
                end else if (run_q == 8'd1) phase_q <= 2'd1;
              end
            end
          end
        end
      endcase
      if (state_q == ST_PIX) begin
        drain_q <= eol_q ? '0 : drain_q + 14'd1;
        if (eol_q) ready_q <= 1'b0;
      end
    end
  end
endmodule

`default_nettype wire

// ===== rtl/core/rgbe_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGBE decoder port checker
// Port-level checks bound to the decoder top level.
// ----------------------------------------------------------------------------
module rgbe_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [4:0]  m_axis_tuser,
  input wire [95:0] m_axis_tdata,
  input wire        s_axis_tready
);
  // Hold result until transferred
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  // Error result carries no pixel
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[4:3] != 2'd0 |-> !m_axis_tuser[0] && m_axis_tdata == 96'd0)
    else $error("error with pixel");
  // Pixel result carries no error
  a_pix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[4:3] == 2'd0)
    else $error("pixel with error");
  // Input stalls while a result waits
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input open");
endmodule

bind rgbe_rle_scanline_decoder rgbe_checker u_chk (.*);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGBE scanline decoder testbench
// Streams one image through the decoder: a directed scanline, one wide
// scanline under a long output stall, random run-length scanlines, then
// either a raw-pixel tail that completes the image or a decode error. Every
// result transfer is checked against a behavioural decoder kept in this file.
// ----------------------------------------------------------------------------
module tb;
  import rgbe_pkg::*;

  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned SettleCycles = 140;
  localparam int unsigned ImageLines   = 40;
  localparam int unsigned RawReserve   = 40;
  localparam int unsigned SmallWidthHi = 24;
  localparam int unsigned WideWidth    = 128;

  typedef struct packed {
    logic        valid;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic        eol;
    logic        eoi;
    logic [1:0]  err;
  } pixel_t;

  typedef enum logic [1:0] {PH_HEADER, PH_CODE, PH_RUN, PH_LITERAL} phase_e;
  typedef enum logic [1:0] {ROW_PREDICT, ROW_ZERO_PIXEL, ROW_NO_RESULT} row_kind_e;

  typedef struct {
    logic      cmd;
    logic [7:0] val;
    row_kind_e kind;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // byte_value
  logic [0:0]  s_axis_tuser;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;   // red, green, blue
  logic [4:0]  m_axis_tuser;   // pixel_valid, end_of_line, end_of_image, error_code

  rgbe_rle_scanline_decoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Pixels still owed by the decoder, oldest first
  pixel_t      pending_pixels[$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  bit          calm         = 1'b0;

  // Behavioural decoder state
  logic [7:0]  line_mem[StoreDepth];
  int unsigned img_width   = 8;
  int unsigned img_height  = 1;
  bit          raw_mode    = 1'b0;
  bit          halted      = 1'b0;
  bit          begun       = 1'b0;
  bit          line_ready  = 1'b0;
  int unsigned plane_sel   = 0;
  int unsigned plane_pos   = 0;
  phase_e      phase       = PH_HEADER;
  int unsigned run_left    = 0;
  logic [23:0] gather      = '0;
  int unsigned gather_cnt  = 0;
  int unsigned drain_pos   = 0;
  int unsigned pixels_left = 0;

  // Value m * 2^(e-136) as single-precision bits, e nonzero
  function automatic logic [31:0] rgbe_to_float(input int unsigned m, input int unsigned e);
    int k;
    int p;
    int be;
    k = int'(e) - 136;
    p = 7;
    if (m == 0) return 32'd0;
    while (((m >> p) & 1) == 0) p--;
    be = p + k + 127;
    if (be >= 1) return (32'(be) << 23) | ((32'(m) << (23 - p)) & 32'h7FFFFF);
    return 32'(m) << (k + 149);
  endfunction

  function automatic logic [7:0] store_rd(input int unsigned plane, input int unsigned pos);
    int unsigned a;
    a = plane * img_width + pos;
    return (a < StoreDepth) ? line_mem[a] : 8'd0;
  endfunction

  task automatic store_wr(input logic [7:0] v);
    int unsigned a;
    a = plane_sel * img_width + plane_pos;
    if (a < StoreDepth) line_mem[a] = v;
    plane_pos++;
  endtask

  function automatic pixel_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] bl, input logic [7:0] e,
                                        input bit eol);
    pixel_t px;
    px = '0;
    if (e != 0) begin
      px.red   = rgbe_to_float(r, e);
      px.green = rgbe_to_float(g, e);
      px.blue  = rgbe_to_float(bl, e);
    end
    pixels_left--;
    px.valid = 1'b1;
    px.eol   = eol;
    px.eoi   = (pixels_left == 0);
    return px;
  endfunction

  // Close a plane when full, else wait for the next code once a run is spent
  task automatic plane_advance();
    if (plane_pos >= img_width) begin
      plane_pos = 0;
      if (plane_sel >= 3) begin
        plane_sel  = 0;
        line_ready = 1'b1;
        drain_pos  = 0;
        phase      = PH_HEADER;
      end else begin
        plane_sel++;
        phase = PH_CODE;
      end
    end else if (run_left == 0) begin
      phase = PH_CODE;
    end
  endtask

  task automatic decode_step(input logic cmd, input logic [7:0] b, output bit got,
                             output pixel_t px);
    int unsigned w;
    int unsigned i;
    int unsigned rem;
    int unsigned count;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    bit          eol;
    got = 1'b0;
    px  = '0;
    w   = img_width;
    if (halted) return;
    if (!begun) begin
      begun       = 1'b1;
      pixels_left = w * img_height;
      drain_pos   = 0;
    end
    if (pixels_left == 0) return;

    if (cmd == CMD_PULL) begin
      if (raw_mode || !line_ready) return;
      i         = drain_pos;
      eol       = (i + 1 >= w);
      drain_pos = eol ? 0 : i + 1;
      if (eol) line_ready = 1'b0;
      got = 1'b1;
      px  = make_pixel(store_rd(0, i), store_rd(1, i), store_rd(2, i), store_rd(3, i), eol);
      return;
    end

    if (line_ready) begin
      halted = 1'b1;
      got    = 1'b1;
      px.err = ERR_OVERRUN;
      return;
    end

    case (phase)
      PH_HEADER: begin
        if (gather_cnt < 3) begin
          gather = {gather[15:0], b};
          gather_cnt++;
          return;
        end
        b0         = gather[23:16];
        b1         = gather[15:8];
        b2         = gather[7:0];
        gather     = '0;
        gather_cnt = 0;
        if (!raw_mode && w >= 8 && b0 == 8'd2 && b1 == 8'd2 && !b2[7]) begin
          if (int'({b2, b}) != w || w > MaxWidth) begin
            halted = 1'b1;
            got    = 1'b1;
            px.err = ERR_WIDTH;
          end else begin
            plane_sel = 0;
            plane_pos = 0;
            run_left  = 0;
            phase     = PH_CODE;
          end
          return;
        end
        raw_mode  = 1'b1;
        eol       = (drain_pos + 1 >= w);
        drain_pos = eol ? 0 : drain_pos + 1;
        got       = 1'b1;
        px        = make_pixel(b0, b1, b2, b, eol);
      end
      PH_CODE: begin
        rem   = (plane_pos < w) ? w - plane_pos : 0;
        count = (b > 128) ? b - 128 : b;
        if (count == 0 || count > rem) begin
          halted = 1'b1;
          got    = 1'b1;
          px.err = ERR_RUN;
          return;
        end
        run_left = count;
        phase    = (b > 128) ? PH_RUN : PH_LITERAL;
      end
      PH_RUN: begin
        while (run_left > 0) begin
          store_wr(b);
          run_left--;
        end
        plane_advance();
      end
      default: begin
        store_wr(b);
        if (run_left > 0) run_left--;
        if (run_left == 0 || plane_pos >= w) begin
          if (plane_pos >= w) run_left = 0;
          plane_advance();
        end
      end
    endcase
  endtask

  // Offer one item, wait for its transfer, then log what it should produce
  task automatic push_item(input logic cmd, input logic [7:0] b,
                           input row_kind_e kind = ROW_PREDICT);
    bit     got;
    pixel_t px;
    if (!calm && $urandom_range(0, 11) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= b;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    decode_step(cmd, b, got, px);
    case (kind)
      ROW_PREDICT: if (got) pending_pixels.push_back(px);
      ROW_ZERO_PIXEL: begin
        px       = '0;
        px.valid = 1'b1;
        pending_pixels.push_back(px);
      end
      default: ;
    endcase
  endtask

  // Register write once the decoder has gone quiet
  task automatic write_reg(input logic [1:0] idx, input int unsigned v);
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx[0:0];
    cfg_data_i  <= 16'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_WIDTH) img_width = v & 32'h3FFF;
    else img_height = v & 32'hFFFF;
  endtask

  // Marker, four planes of random run and literal codes, optional drain
  task automatic send_scanline(input int unsigned w, input int unsigned lit_odds,
                               input bit drain);
    int unsigned pos;
    int unsigned n;
    int unsigned cap;
    push_item(CMD_DATA, 8'd2);
    push_item(CMD_DATA, 8'd2);
    push_item(CMD_DATA, 8'(w >> 8));
    push_item(CMD_DATA, 8'(w));
    for (int p = 0; p < 4; p++) begin
      pos = 0;
      while (pos < w) begin
        // stray pull while the line is still filling
        if ($urandom_range(0, 15) == 0) push_item(CMD_PULL, 8'($urandom));
        if ($urandom_range(0, lit_odds) == 0) begin
          cap = (w - pos < 128) ? w - pos : 128;
          n   = ($urandom_range(0, 3) == 0) ? cap : $urandom_range(1, cap);
          push_item(CMD_DATA, 8'(n));
          repeat (n) push_item(CMD_DATA, 8'($urandom));
        end else begin
          cap = (w - pos < 127) ? w - pos : 127;
          n   = ($urandom_range(0, 3) == 0) ? cap : $urandom_range(1, cap);
          push_item(CMD_DATA, 8'(128 + n));
          push_item(CMD_DATA, 8'($urandom));
        end
        pos += n;
      end
    end
    if (drain) begin
      repeat (w) push_item(CMD_PULL, 8'($urandom));
    end
  endtask

  // Check each result transfer and watch for a stuck pipe
  always @(negedge clk_i) begin
    pixel_t seen;
    pixel_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("tb: errors");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        seen.valid = m_axis_tuser[0];
        seen.eol   = m_axis_tuser[1];
        seen.eoi   = m_axis_tuser[2];
        seen.err   = m_axis_tuser[4:3];
        seen.red   = m_axis_tdata[31:0];
        seen.green = m_axis_tdata[63:32];
        seen.blue  = m_axis_tdata[95:64];
        if (pending_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: v=%b r=%h g=%h b=%h eol=%b eoi=%b err=%0d",
                     seen.valid, seen.red, seen.green, seen.blue, seen.eol, seen.eoi,
                     seen.err);
          end
        end else begin
          want = pending_pixels.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("exp: v=%b r=%h g=%h b=%h eol=%b eoi=%b err=%0d",
                       want.valid, want.red, want.green, want.blue, want.eol, want.eoi,
                       want.err);
              $display("got: v=%b r=%h g=%h b=%h eol=%b eoi=%b err=%0d",
                       seen.valid, seen.red, seen.green, seen.blue, seen.eol, seen.eoi,
                       seen.err);
            end
          end
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off, steady at the end
  initial begin
    bit long_hold_done;
    long_hold_done = 1'b0;
    m_axis_tready  = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!long_hold_done && results_seen >= 40) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t    rows[$];
    logic [1:0]  finish_kind;
    int unsigned w;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(REG_WIDTH, 8);
    write_reg(REG_HEIGHT, ImageLines);

    // Directed scanline of width 8: pull with nothing pending, marker,
    // runs and literals, zero exponents, tiny, huge and exact exponents
    rows.push_back('{CMD_PULL, 8'h00, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h02, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h02, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h00, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h08, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h88, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'hFF, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h88, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h00, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h02, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h01, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h80, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h86, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h7F, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h84, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h00, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h04, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h01, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'hFF, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h88, ROW_NO_RESULT});
    rows.push_back('{CMD_DATA, 8'h89, ROW_NO_RESULT});
    repeat (4) rows.push_back('{CMD_PULL, 8'hFF, ROW_ZERO_PIXEL});
    repeat (4) rows.push_back('{CMD_PULL, 8'h5A, ROW_PREDICT});
    foreach (rows[i]) push_item(rows[i].cmd, rows[i].val, rows[i].kind);

    // Wide line, mostly long runs, drained under the receiver hold-off
    write_reg(REG_HEIGHT, 16'hFFFF);
    write_reg(REG_WIDTH, WideWidth);
    send_scanline(WideWidth, 7, 1'b1);

    write_reg(REG_HEIGHT, 1);
    write_reg(REG_WIDTH, $urandom_range(8, SmallWidthHi));
    while (pixels_left > RawReserve + SmallWidthHi) begin
      if ($urandom_range(0, 3) == 0) write_reg(REG_WIDTH, $urandom_range(8, SmallWidthHi));
      send_scanline(img_width, 1, 1'b1);
    end

    // Tail: raw pixels up to the end of the image, or one decode error
    finish_kind = $urandom_range(0, 1) ? ERR_NONE : 2'($urandom_range(1, 3));
    calm = 1'b1;
    case (finish_kind)
      ERR_NONE: begin
        case ($urandom_range(0, 2))
          0: write_reg(REG_WIDTH, 1);
          1: write_reg(REG_WIDTH, $urandom_range(2, 7));
          default: ;
        endcase
        push_item(CMD_DATA, 8'($urandom_range(3, 255)));
        repeat (3) push_item(CMD_DATA, 8'($urandom));
        while (pixels_left > 0) begin
          if ($urandom_range(0, 7) == 0) push_item(CMD_PULL, 8'($urandom));
          repeat (4) push_item(CMD_DATA, 8'($urandom));
        end
      end
      ERR_WIDTH: begin
        w = img_width + 1;
        push_item(CMD_DATA, 8'd2);
        push_item(CMD_DATA, 8'd2);
        push_item(CMD_DATA, 8'(w >> 8));
        push_item(CMD_DATA, 8'(w));
      end
      ERR_RUN: begin
        push_item(CMD_DATA, 8'd2);
        push_item(CMD_DATA, 8'd2);
        push_item(CMD_DATA, 8'(img_width >> 8));
        push_item(CMD_DATA, 8'(img_width));
        push_item(CMD_DATA, $urandom_range(0, 1) ? 8'd0 : 8'(129 + img_width));
      end
      default: begin
        send_scanline(img_width, 1, 1'b0);
        push_item(CMD_DATA, 8'($urandom));
      end
    endcase
    // Decoder is finished or halted: nothing more may come out
    repeat (10) push_item(1'($urandom), 8'($urandom));
    s_axis_tvalid <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
